@@ design/lpk_pkg.sv @@
// ----------------------------------------------------------------------------
// lpk_pkg
// shared types and constants for the linear probe key index table
// ----------------------------------------------------------------------------
`default_nettype none

package lpk_pkg;

    // fixed field widths
    localparam int KEY_W       = 64;
    localparam int ENTRY_IDX_W = 5;

    // default sizes, handed to the top level parameters
    localparam int TABLE_SLOTS_DEF = 64;
    localparam int MAX_ENTRIES_DEF = 32;

    // key bits folded into the home slot remainder per cycle
    localparam int HASH_BITS_PER_STEP = 4;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

`default_nettype wire

@@ design/lpk_ram.sv @@
// ----------------------------------------------------------------------------
// lpk_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lpk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/lpk_hash.sv @@
// ----------------------------------------------------------------------------
// lpk_hash
// home slot unit: key modulo table size, a mask for a power-of-two size,
// otherwise a remainder folded a few key bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lpk_hash #(
    parameter int TABLE_SLOTS = lpk_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [lpk_pkg::KEY_W-1:0]      key_in,
    output logic                                done,
    output logic [$clog2(TABLE_SLOTS)-1:0]      home
);

    import lpk_pkg::*;

    localparam int SW = $clog2(TABLE_SLOTS);

    generate
        if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0)
        begin : g_mask
            // power-of-two size: low key bits, ready at once
            assign home = key_in[SW-1:0];
            assign done = start;
        end
        else
        begin : g_fold
            localparam int STEPS  = KEY_W / HASH_BITS_PER_STEP;
            localparam int CW     = $clog2(STEPS);
            localparam logic [SW:0] NMOD = (SW + 1)'(TABLE_SLOTS);

            logic             busy_reg, busy_next;
            logic             done_reg, done_next;
            logic [CW-1:0]    step_reg, step_next;
            logic [KEY_W-1:0] shift_reg, shift_next;
            logic [SW-1:0]    rem_reg, rem_next;

            // fold the next key bits into the remainder, one subtract per bit
            always_comb
            begin
                logic [SW:0] t;
                t          = {1'b0, rem_reg};
                busy_next  = busy_reg;
                done_next  = 1'b0;
                step_next  = step_reg;
                shift_next = shift_reg;
                rem_next   = rem_reg;
                if (start)
                begin
                    busy_next  = 1'b1;
                    step_next  = '0;
                    shift_next = key_in;
                    rem_next   = '0;
                end
                else if (busy_reg)
                begin
                    for (int i = 0; i < HASH_BITS_PER_STEP; i++)
                    begin
                        t = {t[SW-1:0], shift_reg[KEY_W-1-i]};
                        if (t >= NMOD)
                        begin
                            t = t - NMOD;
                        end
                    end
                    rem_next   = t[SW-1:0];
                    shift_next = shift_reg << HASH_BITS_PER_STEP;
                    step_next  = step_reg + 1'b1;
                    if (step_reg == CW'(STEPS - 1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                    step_reg  <= '0;
                    shift_reg <= '0;
                    rem_reg   <= '0;
                end
                else
                begin
                    busy_reg  <= busy_next;
                    done_reg  <= done_next;
                    step_reg  <= step_next;
                    shift_reg <= shift_next;
                    rem_reg   <= rem_next;
                end
            end

            assign home = rem_reg;
            assign done = done_reg;
        end
    endgenerate

endmodule

`default_nettype wire

@@ design/linear_probe_key_index_table.sv @@
// ----------------------------------------------------------------------------
// linear_probe_key_index_table
// open-addressing hash table mapping a 64-bit key to a dense entry index,
// with linear probing over one slot ram
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | action, key
//  out     | output    | out_valid / out_stall | status, entry_index
//
//  an item passes S_IDLE, S_LOOK, one S_CHECK per probed slot and S_EMIT
//  with a power-of-two table; other table sizes wait in S_HASH for the
//  home slot remainder. probing reads one slot per cycle from the slot ram,
//  so the worst case is TABLE_SLOTS probes.
//  after reset a clearing pass over every slot empties the slot ram;
//  in_stall stays high during it.
//  a finished result waits in the output register while the next beat is
//  taken; a full output register holds the block at its last cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_key_index_table #(
    parameter int TABLE_SLOTS = lpk_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_ENTRIES = lpk_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              action,
    input  wire logic [lpk_pkg::KEY_W-1:0]         key,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             status,
    output logic [lpk_pkg::ENTRY_IDX_W-1:0]        entry_index
);

    import lpk_pkg::*;

    localparam int AW     = $clog2(TABLE_SLOTS);
    localparam int EW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W = 1 + EW + KEY_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_LOOK,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [AW-1:0]    probe_reg, probe_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             action_reg, action_next;
    logic [KEY_W-1:0] key_reg, key_next;
    status_t          res_status_reg, res_status_next;
    logic [EW-1:0]    res_entry_reg, res_entry_next;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [EW-1:0]    entry_reg, entry_next;

    logic             in_take;
    logic             hash_done;
    logic [AW-1:0]    hash_home;
    logic [AW-1:0]    pos_inc;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic             slot_used;
    logic [EW-1:0]    slot_entry;
    logic [KEY_W-1:0] slot_key;
    logic             slot_match;
    logic             probe_stop;
    logic             probe_last;
    logic             ins_ok;
    logic [31:0]      entry_wide;

    // input handshake
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    // home slot unit
    lpk_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_take),
        .key_in (key),
        .done   (hash_done),
        .home   (hash_home)
    );

    // slot word: used bit, entry index, key
    assign slot_used  = ram_rdata[WORD_W-1];
    assign slot_entry = ram_rdata[KEY_W +: EW];
    assign slot_key   = ram_rdata[KEY_W-1:0];
    assign slot_match = slot_used && (slot_key == key_reg);
    assign probe_stop = !slot_used || slot_match;
    assign probe_last = (probe_reg == AW'(TABLE_SLOTS - 1));
    assign pos_inc    = (pos_reg == AW'(TABLE_SLOTS - 1)) ? '0 : pos_reg + 1'b1;

    // an insert that fills the probed slot
    assign ins_ok = (state_reg == S_CHECK) && action_reg && probe_stop && !slot_match
                    && (cnt_reg < CW'(MAX_ENTRIES));

    // slot ram access: clearing pass, probe reads, insert write
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = {1'b1, cnt_reg[EW-1:0], key_reg};
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (ins_ok)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re    = (state_reg == S_LOOK) || (state_reg == S_CHECK);
    assign ram_raddr = (state_reg == S_CHECK) ? pos_inc : pos_reg;

    lpk_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        pos_next        = pos_reg;
        probe_next      = probe_reg;
        cnt_next        = cnt_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        entry_next      = entry_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    action_next = action;
                    key_next    = key;
                    probe_next  = '0;
                    if (hash_done)
                    begin
                        pos_next   = hash_home;
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    pos_next   = hash_home;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (probe_stop || probe_last)
                begin
                    state_next     = S_EMIT;
                    res_entry_next = '0;
                    if (!action_reg)
                    begin
                        if (slot_match)
                        begin
                            res_status_next = ST_OK;
                            res_entry_next  = slot_entry;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    else if (cnt_reg >= CW'(MAX_ENTRIES))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else if (slot_match)
                    begin
                        res_status_next = ST_DUPLICATE;
                    end
                    else if (!probe_stop)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        res_entry_next  = cnt_reg[EW-1:0];
                        cnt_next        = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    pos_next   = pos_inc;
                    probe_next = probe_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    entry_next     = res_entry_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            pos_reg        <= '0;
            probe_reg      <= '0;
            cnt_reg        <= '0;
            action_reg     <= 1'b0;
            key_reg        <= '0;
            res_status_reg <= ST_OK;
            res_entry_reg  <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            entry_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pos_reg        <= pos_next;
            probe_reg      <= probe_next;
            cnt_reg        <= cnt_next;
            action_reg     <= action_next;
            key_reg        <= key_next;
            res_status_reg <= res_status_next;
            res_entry_reg  <= res_entry_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            entry_reg      <= entry_next;
        end
    end

    // output beat
    assign entry_wide  = 32'(entry_reg);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_index = entry_wide[ENTRY_IDX_W-1:0];

`ifndef SYNTH
    // entry count never passes its limit
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above limit");

    // a filled slot takes exactly one new entry index
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("entry count did not advance on insert");

    // slot ram is written only by the clearing pass or an insert decision
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_CHECK))
        else $error("slot write outside clear or check");

    // a result that is not ok carries a zero entry index
    a_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (entry_index == '0))
        else $error("nonzero entry index on failed result");

    // no beat is taken while the slot ram is being cleared
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("input taken during clearing pass");
`endif

endmodule

`default_nettype wire

@@ verif/linear_probe_key_index_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_key_index_table_checker
// watches both channels of the key index table and keeps its own copy of the
// slot store. every accepted request beat is run through the copy to give the
// awaited status and entry index, and every accepted result beat is checked
// in order against them.
// ----------------------------------------------------------------------------

module linear_probe_key_index_table_checker #(
    parameter int TABLE_SLOTS = lpk_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_ENTRIES = lpk_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              action,
    input  logic [lpk_pkg::KEY_W-1:0]         key,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [1:0]                        status,
    input  logic [lpk_pkg::ENTRY_IDX_W-1:0]   entry_index,
    output int                                failures,
    output int                                outstanding,
    output int                                results_seen,
    output int                                inserts_taken,
    output int                                lookup_hits,
    output int                                inserts_refused
);

    import lpk_pkg::*;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef struct packed {
        status_t                  status;
        logic [ENTRY_IDX_W-1:0]   entry;
    } index_result_t;

    // shadow of the slot store
    bit                 shadow_used  [TABLE_SLOTS];
    logic [KEY_W-1:0]   shadow_key   [TABLE_SLOTS];
    int                 shadow_entry [TABLE_SLOTS];
    int                 entries_taken;

    index_result_t      due_results [$];

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        failures = failures + 1;
    endtask

    // walk the shadow table for one request and apply an insert
    task automatic probe_table(input logic act, input logic [KEY_W-1:0] k,
                               output index_result_t res);
        int  pos;
        int  where;
        int  n;
        bit  stopped;
        bit  present;
        pos     = k % TABLE_SLOTS;
        where   = 0;
        stopped = 1'b0;
        for (n = 0; n < TABLE_SLOTS && !stopped; n++)
        begin
            if (!shadow_used[pos] || shadow_key[pos] == k)
            begin
                stopped = 1'b1;
                where   = pos;
            end
            else
            begin
                pos = (pos + 1) % TABLE_SLOTS;
            end
        end
        present   = stopped && shadow_used[where];
        res.entry = '0;
        if (act == ACT_LOOKUP)
        begin
            if (present)
            begin
                res.status  = ST_OK;
                res.entry   = shadow_entry[where][ENTRY_IDX_W-1:0];
                lookup_hits = lookup_hits + 1;
            end
            else
            begin
                res.status = ST_NOT_FOUND;
            end
        end
        else
        begin
            // entry limit wins over a duplicate
            if (entries_taken >= MAX_ENTRIES)
                res.status = ST_FULL;
            else if (present)
                res.status = ST_DUPLICATE;
            else if (!stopped)
                res.status = ST_FULL;
            else
            begin
                res.status          = ST_OK;
                res.entry           = entries_taken[ENTRY_IDX_W-1:0];
                shadow_used[where]  = 1'b1;
                shadow_key[where]   = k;
                shadow_entry[where] = entries_taken;
                entries_taken       = entries_taken + 1;
                inserts_taken       = inserts_taken + 1;
            end
            if (res.status != ST_OK)
                inserts_refused = inserts_refused + 1;
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        index_result_t want;
        index_result_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                shadow_used[i]  = 1'b0;
                shadow_key[i]   = '0;
                shadow_entry[i] = 0;
            end
            entries_taken   = 0;
            due_results.delete();
            failures        = 0;
            outstanding     = 0;
            results_seen    = 0;
            inserts_taken   = 0;
            lookup_hits     = 0;
            inserts_refused = 0;
        end
        else
        begin
            // result beat against the oldest awaited result
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                results_seen = results_seen + 1;
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("result beat status=%0d entry=%0d with none due",
                                              status, entry_index));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d want %s",
                                                  status, want.status.name()));
                    if (entry_index !== want.entry)
                        report_mismatch($sformatf("entry_index got %0d want %0d",
                                                  entry_index, want.entry));
                end
            end
            // request beat into the shadow table
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                probe_table(action, key, fresh);
                due_results.push_back(fresh);
            end
            outstanding = due_results.size();
        end
    end

endmodule

@@ verif/linear_probe_key_index_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_key_index_table_tb
// drives lookups and inserts into the key index table with random gaps and
// output stalls; a checker beside the block predicts and compares every
// result beat. directed beats cover empty table, wrapping probes, keys that
// differ only in the top bit, duplicates; random beats fill the table past
// its entry limit and keep probing colliding home slots.
// ----------------------------------------------------------------------------

module linear_probe_key_index_table_tb;

    import lpk_pkg::*;

    localparam int TABLE_SLOTS  = TABLE_SLOTS_DEF;
    localparam int MAX_ENTRIES  = MAX_ENTRIES_DEF;
    localparam int RANDOM_BEATS = 1100;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 699;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int POOL_DEPTH   = 256;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     action;
    logic [KEY_W-1:0]         key;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               status;
    logic [ENTRY_IDX_W-1:0]   entry_index;

    int                       failures;
    int                       outstanding;
    int                       results_seen;
    int                       inserts_taken;
    int                       lookup_hits;
    int                       inserts_refused;

    bit                       calm;
    int                       cycle_count;
    int                       beats_sent;
    logic [KEY_W-1:0]         inserted_keys [$];

    linear_probe_key_index_table #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_index (entry_index)
    );

    linear_probe_key_index_table_checker #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .key             (key),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .entry_index     (entry_index),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_seen    (results_seen),
        .inserts_taken   (inserts_taken),
        .lookup_hits     (lookup_hits),
        .inserts_refused (inserts_refused)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter and watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
        $display("simulation failed");
        $finish;
    end

    // result side stalls at random outside the calm stretch
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= !calm && ($urandom_range(99) < 9);
    end

    // one request beat, with an optional random gap before it
    task automatic send_request(input logic act, input logic [KEY_W-1:0] k);
        while (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        beats_sent = beats_sent + 1;
        if (act == ACT_INSERT && inserted_keys.size() < POOL_DEPTH)
            inserted_keys.push_back(k);
    endtask

    // key mix: known keys, near misses, crowded home slots, plain random
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int               r;
        r = $urandom_range(99);
        k = {$urandom, $urandom};
        if (r < 40 && inserted_keys.size() > 0)
        begin
            k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        end
        else if (r < 50 && inserted_keys.size() > 0)
        begin
            k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
            k[$urandom_range(KEY_W - 1)] ^= 1'b1;
        end
        else if (r < 80)
        begin
            // crowd a few home slots, the top ones so that probes wrap
            case ($urandom_range(5))
                0: k[5:0] = 6'd0;
                1: k[5:0] = 6'd1;
                2: k[5:0] = 6'd2;
                3: k[5:0] = 6'd3;
                4: k[5:0] = 6'd62;
                default: k[5:0] = 6'd63;
            endcase
        end
        return k;
    endfunction

    // stimulus and verdict
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_LOOKUP;
        key         = '0;
        out_stall   = 1'b0;
        calm        = 1'b0;
        cycle_count = 0;
        beats_sent  = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed beats
        send_request(ACT_LOOKUP, 64'h0000_0000_0000_0000);
        send_request(ACT_INSERT, 64'h0000_0000_0000_0000);
        send_request(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_INSERT, 64'h0000_0000_0000_003F);
        send_request(ACT_LOOKUP, 64'h0000_0000_0000_003F);
        send_request(ACT_INSERT, 64'h0000_0000_0000_0000);
        send_request(ACT_INSERT, 64'h8000_0000_0000_0000);
        send_request(ACT_LOOKUP, 64'h8000_0000_0000_0000);
        send_request(ACT_LOOKUP, 64'h4000_0000_0000_0000);
        send_request(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_INSERT, 64'h5555_5555_5555_5555);
        send_request(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ACT_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAB);
        send_request(ACT_LOOKUP, 64'h0000_0000_0000_0000);

        // random beats, inserts run the table up to its entry limit
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            calm = (i >= CALM_FIRST && i <= CALM_LAST);
            send_request(($urandom_range(99) < 35) ? ACT_INSERT : ACT_LOOKUP, pick_key());
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain
        wait (outstanding == 0);
        repeat (TABLE_SLOTS + 16) @(posedge clk);

        $display("%0d request beats, %0d result beats checked", beats_sent, results_seen);
        $display("%0d inserts taken, %0d refused, %0d lookup hits",
                 inserts_taken, inserts_refused, lookup_hits);
        if (failures == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
